>>> rtl/core/cssb_pkg.sv
// cssb_pkg: shared types and constants of the calorimeter sector seed binner
// word layout of a tower moving through the cell row, config record, sector centres
// no dependencies

package cssb_pkg;

  localparam int SECTORS   = 24;
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = 2;
  localparam int RES_CNT_W = 3;

  // angle units of 2^-12 rad
  localparam logic signed [17:0] PI_FX     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_FX = 18'sd25736;

  // configuration register indexes
  localparam logic [1:0] REG_ENERGY_THR = 2'd0;
  localparam logic [1:0] REG_Z_EDGE     = 2'd1;
  localparam logic [1:0] REG_MAX_DIFF   = 2'd2;
  localparam logic [1:0] REG_SEED_LIMIT = 2'd3;

  localparam logic [15:0] RST_ENERGY_THR = 16'd128;
  localparam logic [12:0] RST_Z_EDGE     = 13'd320;
  localparam logic [13:0] RST_MAX_DIFF   = 14'd1482;
  localparam logic [7:0]  RST_SEED_LIMIT = 8'd200;

  typedef struct packed {
    logic [15:0] energy_thr;
    logic [12:0] z_edge;
    logic [13:0] max_diff;
    logic [7:0]  seed_limit;
  } cfg_t;

  typedef struct packed {
    logic [4:0] sector;
    logic [7:0] slot;
    logic       full;
  } seed_res_t;

  typedef struct packed {
    logic                   valid;
    logic                   cmd;
    logic                   e_ok;
    logic signed [15:0]     phi;
    logic signed [13:0]     z;
    logic [RES_CNT_W-1:0]   n;
    seed_res_t [MAX_RES-1:0] res;
  } tower_t;

  // sector centre azimuth, round(m*pi/6 * 4096)
  function automatic logic [14:0] centre_angle(input logic [4:0] idx);
    logic [14:0] c;
    case (idx)
      5'd0:  c = 15'd4289;
      5'd1:  c = 15'd2145;
      5'd2:  c = 15'd0;
      5'd3:  c = 15'd23591;
      5'd4:  c = 15'd21447;
      5'd5:  c = 15'd19302;
      5'd6:  c = 15'd17157;
      5'd7:  c = 15'd15013;
      5'd8:  c = 15'd12868;
      5'd9:  c = 15'd10723;
      5'd10: c = 15'd8579;
      5'd11: c = 15'd6434;
      5'd12: c = 15'd8579;
      5'd13: c = 15'd10723;
      5'd14: c = 15'd12868;
      5'd15: c = 15'd15013;
      5'd16: c = 15'd17157;
      5'd17: c = 15'd19302;
      5'd18: c = 15'd21447;
      5'd19: c = 15'd23591;
      5'd20: c = 15'd0;
      5'd21: c = 15'd2145;
      5'd22: c = 15'd4289;
      5'd23: c = 15'd6434;
      default: c = 15'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/cssb_cell.sv
// cssb_cell: one sector of the binner row, holds that sector's seed counter
// tests the passing tower word and appends its result; depends on cssb_pkg

module cssb_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv_i,
  input  cssb_pkg::cfg_t  cfg_i,
  input  cssb_pkg::tower_t tw_i,
  output cssb_pkg::tower_t tw_o
);
  import cssb_pkg::*;

  localparam logic [4:0]  SECT   = 5'(IDX);
  localparam logic [14:0] CENTRE = centre_angle(5'(IDX));

  tower_t            tw_r, tw_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic signed [17:0] d, a1, a2, a3, ad;
  logic signed [14:0] zs, es;
  logic              zone_ok, angle_ok, match;

  always_comb begin
    d  = 18'(signed'(tw_i.phi)) - signed'({3'b000, CENTRE});
    a1 = d[17] ? -d : d;
    a2 = (a1 > PI_FX) ? a1 - TWO_PI_FX : a1;
    a3 = (a2 > PI_FX) ? a2 - TWO_PI_FX : a2;
    ad = a3[17] ? -a3 : a3;
    angle_ok = ad <= signed'({4'b0000, cfg_i.max_diff});
  end

  always_comb begin
    zs = {tw_i.z[13], tw_i.z};
    es = signed'({2'b00, cfg_i.z_edge});
    if (IDX < SECTORS / 2) begin
      zone_ok = zs > -es;
    end else begin
      zone_ok = zs < es;
    end
  end

  assign match = tw_i.valid && !tw_i.cmd && tw_i.e_ok && zone_ok && angle_ok &&
                 (tw_i.n != RES_CNT_W'(MAX_RES));

  always_comb begin
    tw_nxt  = tw_i;
    cnt_nxt = cnt_r;
    if (tw_i.valid && tw_i.cmd) begin
      cnt_nxt = 8'd0;
    end else if (match) begin
      tw_nxt.res[tw_i.n[RES_IDX_W-1:0]].sector = SECT;
      if (cnt_r >= cfg_i.seed_limit) begin
        tw_nxt.res[tw_i.n[RES_IDX_W-1:0]].slot = cfg_i.seed_limit;
        tw_nxt.res[tw_i.n[RES_IDX_W-1:0]].full = 1'b1;
      end else begin
        tw_nxt.res[tw_i.n[RES_IDX_W-1:0]].slot = cnt_r;
        tw_nxt.res[tw_i.n[RES_IDX_W-1:0]].full = 1'b0;
        cnt_nxt = cnt_r + 8'd1;
      end
      tw_nxt.n = tw_i.n + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r.valid <= 1'b0;
      cnt_r      <= 8'd0;
    end else if (adv_i) begin
      tw_r  <= tw_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign tw_o = tw_r;

endmodule

>>> rtl/core/cssb_out_buf.sv
// cssb_out_buf: two-entry buffer of finished tower words at the end of the row
// hands out one result word per cycle from the head entry while out_stall is low; depends on cssb_pkg

module cssb_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  cssb_pkg::tower_t   push_tw_i,
  output logic               full_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_sector,
  output logic [7:0]         out_slot,
  output logic signed [15:0] out_seed_phi,
  output logic signed [13:0] out_seed_z,
  output logic               out_full_res,
  output logic               out_last
);
  import cssb_pkg::*;

  tower_t               rec_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           cnt_r;
  logic [RES_IDX_W-1:0] idx_r;
  tower_t               head;
  seed_res_t            sel;
  logic                 take, pop;

  assign head = rec_r[rd_ptr_r];
  assign sel  = head.res[idx_r];

  assign out_valid    = cnt_r != 2'd0;
  assign full_o       = cnt_r == 2'd2;
  assign out_sector   = sel.sector;
  assign out_slot     = sel.slot;
  assign out_full_res = sel.full;
  assign out_seed_phi = head.phi;
  assign out_seed_z   = head.z;
  assign out_last     = (RES_CNT_W'(idx_r) + RES_CNT_W'(1)) == head.n;

  assign take = out_valid && !out_stall;
  assign pop  = take && out_last;

  always_ff @(posedge clk) begin
    if (push_i) begin
      rec_r[wr_ptr_r] <= push_tw_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (take) begin
        idx_r <= out_last ? '0 : idx_r + RES_IDX_W'(1);
      end
      if (push_i && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push_i) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/calorimeter_sector_seed_binner.sv
// calorimeter_sector_seed_binner: top level, row of 24 sector cells plus output buffer
// depends on cssb_pkg, cssb_cell, cssb_out_buf
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | cmd, energy, phi, z_pos
//   out_    | output    | out_valid/out_stall | sector, slot, seed_phi, seed_z, full_res, last
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// a word enters the cell row every cycle while in_stall is low; it moves one sector cell
// per cycle while the row advances and passes every cell register before its results
// reach the output buffer. results leave one per cycle while out_stall is low. reset
// clears all sector counters at once. a stall on the output freezes the whole row only
// when the two-entry output buffer is full and the row end holds results.

module calorimeter_sector_seed_binner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [15:0]        in_energy,
  input  logic signed [15:0] in_phi,
  input  logic signed [13:0] in_z_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_sector,
  output logic [7:0]         out_slot,
  output logic signed [15:0] out_seed_phi,
  output logic signed [13:0] out_seed_z,
  output logic               out_full_res,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import cssb_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  tower_t tw [0:SECTORS];
  tower_t tail;
  logic   adv, push, buf_full, tail_has_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENERGY_THR: cfg_nxt.energy_thr = cfg_wdata;
        REG_Z_EDGE:     cfg_nxt.z_edge     = cfg_wdata[12:0];
        REG_MAX_DIFF:   cfg_nxt.max_diff   = cfg_wdata[13:0];
        REG_SEED_LIMIT: cfg_nxt.seed_limit = cfg_wdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_thr <= RST_ENERGY_THR;
      cfg_r.z_edge     <= RST_Z_EDGE;
      cfg_r.max_diff   <= RST_MAX_DIFF;
      cfg_r.seed_limit <= RST_SEED_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // word entering the row
  always_comb begin
    tw[0]       = '0;
    tw[0].valid = in_valid;
    tw[0].cmd   = in_cmd;
    tw[0].e_ok  = in_energy >= cfg_r.energy_thr;
    tw[0].phi   = in_phi;
    tw[0].z     = in_z_pos;
  end

  // whole row moves together; only a word carrying results needs buffer room
  assign tail         = tw[SECTORS];
  assign tail_has_res = tail.valid && (tail.n != '0);
  assign adv          = !tail_has_res || !buf_full;
  assign push         = tail_has_res && adv;
  assign in_stall     = !adv;

  for (genvar k = 0; k < SECTORS; k++) begin : g_cell
    cssb_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv_i (adv),
      .cfg_i (cfg_r),
      .tw_i  (tw[k]),
      .tw_o  (tw[k+1])
    );
  end

  cssb_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_tw_i    (tail),
    .full_o       (buf_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sector   (out_sector),
    .out_slot     (out_slot),
    .out_seed_phi (out_seed_phi),
    .out_seed_z   (out_seed_z),
    .out_full_res (out_full_res),
    .out_last     (out_last)
  );

endmodule

>>> rtl/core/cssb_checker.sv
// cssb_checker: port-level checks of the seed binner over time
// bound to calorimeter_sector_seed_binner; no package needed

module cssb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_sector,
  input logic [7:0]         out_slot,
  input logic signed [15:0] out_seed_phi,
  input logic signed [13:0] out_seed_z,
  input logic               out_full_res,
  input logic               out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sector) && $stable(out_slot) &&
    $stable(out_full_res) && $stable(out_last))
    else $error("stalled result word changed");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sector <= 5'd23)
    else $error("sector index out of range");

  // results of one tower follow back to back in rising sector order
  a_sector_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && (out_sector > $past(out_sector)))
    else $error("results of one tower not in sector order");

  a_same_tower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
    out_seed_phi == $past(out_seed_phi) && out_seed_z == $past(out_seed_z))
    else $error("tower fields changed within one tower");

endmodule

bind calorimeter_sector_seed_binner cssb_checker u_cssb_checker (.*);

>>> sim/seed_binner_checker.sv
`timescale 1ns / 1ps
// seed_binner_checker: watches the tower, seed and config channels of the seed binner,
// predicts every seed word from its own copy of the counters and settings, compares
// depends on cssb_pkg for the config record, register indexes and reset values

module seed_binner_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic [15:0]        in_energy,
  input  logic signed [15:0] in_phi,
  input  logic signed [13:0] in_z_pos,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_sector,
  input  logic [7:0]         out_slot,
  input  logic signed [15:0] out_seed_phi,
  input  logic signed [13:0] out_seed_z,
  input  logic               out_full_res,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 open_count,
  output int                 word_count,
  output int                 full_count
);
  import cssb_pkg::*;

  localparam int HALF_TURN = 12868;
  localparam int FULL_TURN = 25736;

  typedef struct packed {
    logic [4:0]         sector;
    logic [7:0]         slot;
    logic signed [15:0] phi;
    logic signed [13:0] z;
    logic               full;
    logic               last;
  } seed_word_t;

  cfg_t       settings;
  logic [7:0] seeds_held [SECTORS];
  seed_word_t expected_seeds [$];
  int         fails = 0;
  int         checked = 0;
  int         fulls = 0;

  // center of sector s is m*pi/6 rounded, m running 2,1,0,11..3 then 4..11,0..3
  function automatic int sector_center(input int s);
    int m;
    if (s < 3) m = 2 - s;
    else if (s < 12) m = 14 - s;
    else if (s < 20) m = s - 8;
    else m = s - 20;
    return (m * FULL_TURN + 6) / 12;
  endfunction

  function automatic int azimuth_gap(input int phi, input int center);
    int d;
    d = phi - center;
    if (d < 0) d = -d;
    while (d > HALF_TURN) d -= FULL_TURN;
    if (d < 0) d = -d;
    return d;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t seed word %0d: %s got %0d, want %0d", $time, checked, what, got, want);
    fails++;
  endtask

  task automatic bin_tower(input logic cmd, input logic [15:0] energy,
                           input logic signed [15:0] phi, input logic signed [13:0] z);
    seed_word_t hit [MAX_RES];
    int         n;
    int         margin;
    logic       zone_ok;
    n = 0;
    margin = int'(settings.z_edge);
    if (cmd) begin
      foreach (seeds_held[s]) seeds_held[s] = '0;
      return;
    end
    if (energy < settings.energy_thr) return;
    for (int s = 0; s < SECTORS && n < MAX_RES; s++) begin
      // lower half of the sectors covers the positive-z side plus the overlap
      zone_ok = (s < SECTORS / 2) ? (int'(z) > -margin) : (int'(z) < margin);
      if (zone_ok && azimuth_gap(int'(phi), sector_center(s)) <= int'(settings.max_diff)) begin
        hit[n].sector = 5'(s);
        hit[n].phi = phi;
        hit[n].z = z;
        hit[n].last = 1'b0;
        if (seeds_held[s] >= settings.seed_limit) begin
          hit[n].slot = settings.seed_limit;
          hit[n].full = 1'b1;
        end else begin
          hit[n].slot = seeds_held[s];
          hit[n].full = 1'b0;
          seeds_held[s] = seeds_held[s] + 8'd1;
        end
        n++;
      end
    end
    if (n > 0) hit[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_seeds.push_back(hit[i]);
  endtask

  task automatic check_word();
    seed_word_t want;
    if (expected_seeds.size() == 0) begin
      report("word with nothing expected, sector", int'(out_sector), -1);
      return;
    end
    want = expected_seeds.pop_front();
    checked++;
    if (want.full) fulls++;
    if (out_sector !== want.sector) report("sector", int'(out_sector), int'(want.sector));
    if (out_slot !== want.slot) report("slot", int'(out_slot), int'(want.slot));
    if (out_seed_phi !== want.phi) report("seed_phi", int'(out_seed_phi), int'(want.phi));
    if (out_seed_z !== want.z) report("seed_z", int'(out_seed_z), int'(want.z));
    if (out_full_res !== want.full) report("full_res", int'(out_full_res), int'(want.full));
    if (out_last !== want.last) report("last", int'(out_last), int'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.energy_thr = RST_ENERGY_THR;
      settings.z_edge = RST_Z_EDGE;
      settings.max_diff = RST_MAX_DIFF;
      settings.seed_limit = RST_SEED_LIMIT;
      foreach (seeds_held[s]) seeds_held[s] = '0;
      expected_seeds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENERGY_THR: settings.energy_thr = cfg_wdata;
          REG_Z_EDGE:     settings.z_edge = cfg_wdata[12:0];
          REG_MAX_DIFF:   settings.max_diff = cfg_wdata[13:0];
          REG_SEED_LIMIT: settings.seed_limit = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) bin_tower(in_cmd, in_energy, in_phi, in_z_pos);
      if (out_valid && !out_stall) check_word();
    end
    fail_count <= fails;
    open_count <= expected_seeds.size();
    word_count <= checked;
    full_count <= fulls;
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives towers and register writes into the seed binner under several
// idle and stall mixes, with seed_binner_checker alongside doing the prediction
// depends on cssb_pkg, calorimeter_sector_seed_binner, seed_binner_checker

module testbench;
  import cssb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_TOWERS = 52;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [15:0]        in_energy;
  logic signed [15:0] in_phi;
  logic signed [13:0] in_z_pos;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_sector;
  logic [7:0]         out_slot;
  logic signed [15:0] out_seed_phi;
  logic signed [13:0] out_seed_z;
  logic               out_full_res;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  logic hold_on = 1'b0;
  int   stall_pct = 0;
  int   send_pct;
  int   cur_thr, cur_zmargin, cur_maxd;
  int   towers = 0;
  int   quiet = 0;
  int   fail_count, open_count, word_count, full_count;

  calorimeter_sector_seed_binner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_energy(in_energy),
    .in_phi(in_phi), .in_z_pos(in_z_pos),
    .out_valid(out_valid), .out_stall(out_stall), .out_sector(out_sector),
    .out_slot(out_slot), .out_seed_phi(out_seed_phi), .out_seed_z(out_seed_z),
    .out_full_res(out_full_res), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  seed_binner_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_energy(in_energy),
    .in_phi(in_phi), .in_z_pos(in_z_pos),
    .out_valid(out_valid), .out_stall(out_stall), .out_sector(out_sector),
    .out_slot(out_slot), .out_seed_phi(out_seed_phi), .out_seed_z(out_seed_z),
    .out_full_res(out_full_res), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .open_count(open_count), .word_count(word_count),
    .full_count(full_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_on || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d seed words outstanding",
               QUIET_LIMIT, open_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [15:0] energy,
                           input logic signed [15:0] phi, input logic signed [13:0] z);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_energy <= energy;
    in_phi <= phi;
    in_z_pos <= z;
    do @(posedge clk); while (in_stall);
    towers++;
  endtask

  // wait for every expected seed, then let words without seeds leave the cell row
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] thr, input logic [12:0] zmargin,
                                input logic [13:0] maxd, input logic [7:0] limit);
    logic [15:0] value [4];
    value[REG_ENERGY_THR] = thr;
    value[REG_Z_EDGE] = 16'(zmargin);
    value[REG_MAX_DIFF] = 16'(maxd);
    value[REG_SEED_LIMIT] = 16'(limit);
    cur_thr = int'(thr);
    cur_zmargin = int'(zmargin);
    cur_maxd = int'(maxd);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly towers aimed near a sector center and near the z overlap edges
  task automatic random_tower();
    logic               cmd;
    logic [15:0]        energy;
    logic signed [15:0] phi;
    logic signed [13:0] z;
    int                 p, zi, off, span, k;
    cmd = ($urandom_range(14) == 0);
    if (cur_thr != 0 && $urandom_range(9) == 0) energy = 16'($urandom_range(cur_thr - 1, 0));
    else energy = 16'($urandom_range(65535, cur_thr));
    k = $urandom_range(11);
    span = cur_maxd + cur_maxd / 8 + 2;
    if ($urandom_range(1) == 0) begin
      off = $urandom_range(2 * cur_maxd);
      off = off - cur_maxd;
    end else begin
      off = $urandom_range(2 * span);
      off = off - span;
    end
    p = (k * 25736 + 6) / 12 + off;
    if (p > 25735) p -= 25736;
    if (p < -12868) p += 25736;
    phi = p[15:0];
    if ($urandom_range(9) == 0) phi = 16'($urandom);
    off = $urandom_range(4);
    off = off - 2;
    case ($urandom_range(3))
      0: zi = -cur_zmargin + off;
      1: zi = cur_zmargin + off;
      default: zi = int'($signed(14'($urandom)));
    endcase
    if (zi > 8191) zi = 8191;
    if (zi < -8192) zi = -8192;
    z = zi[13:0];
    send_word(cmd, energy, phi, z);
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall, input int count);
    send_pct = sender_idle;
    stall_pct <= receiver_stall;
    repeat (count) random_tower();
  endtask

  initial begin
    in_valid <= 1'b0;
    in_cmd <= 1'b0;
    in_energy <= '0;
    in_phi <= '0;
    in_z_pos <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENERGY_THR;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    send_pct = 0;
    cur_thr = int'(RST_ENERGY_THR);
    cur_zmargin = int'(RST_Z_EDGE);
    cur_maxd = int'(RST_MAX_DIFF);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold edge, wrap at +-pi, z overlap edges, angle limit edge
    send_word(1'b1, 16'hFFFF, -16'sd1, -14'sd1);
    send_word(1'b0, 16'd127, 16'sd0, 14'sd0);
    send_word(1'b0, 16'd128, 16'sd0, 14'sd0);
    send_word(1'b0, 16'hFFFF, -16'sd12868, 14'sd0);
    send_word(1'b0, 16'hFFFF, 16'sd25735, 14'sd0);
    send_word(1'b0, 16'd300, 16'sd0, -14'sd320);
    send_word(1'b0, 16'd300, 16'sd0, 14'sd320);
    send_word(1'b0, 16'd300, 16'sd0, -14'sd8192);
    send_word(1'b0, 16'd300, 16'sd0, 14'sd8191);
    send_word(1'b0, 16'd300, 16'sd1072, 14'sd0);
    send_word(1'b0, 16'd300, 16'sd1482, 14'sd0);
    send_word(1'b0, 16'd300, 16'sd1483, 14'sd0);
    send_word(1'b0, 16'd300, 16'sh7FFF, 14'sd100);
    send_word(1'b0, 16'd300, 16'sh8000, -14'sd100);

    // every sector matches: only four seeds, then the one-seed limit is hit
    drain();
    write_settings(16'd0, 13'd8191, 14'd12868, 8'd1);
    send_word(1'b0, 16'd0, 16'sd0, 14'sd0);
    send_word(1'b0, 16'd0, 16'sd0, 14'sd0);
    send_word(1'b0, 16'd0, 16'sd12868, 14'sd0);

    // zero limit and zero margins: exact centers only, z = 0 matches nothing
    drain();
    write_settings(16'hFFFF, 13'd0, 14'd0, 8'd0);
    send_word(1'b0, 16'hFFFE, 16'sd4289, 14'sd5);
    send_word(1'b0, 16'hFFFF, 16'sd4289, 14'sd0);
    send_word(1'b0, 16'hFFFF, 16'sd4289, 14'sd1);
    send_word(1'b0, 16'hFFFF, 16'sd4289, -14'sd1);
    send_word(1'b1, 16'd0, 16'sd0, 14'sd0);

    // no idling, with a long receiver hold-off at the start to back up the row
    drain();
    write_settings(16'd1000, 13'd320, 14'd1482, 8'd3);
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    run_phase(0, 0, PHASE_TOWERS);

    drain();
    write_settings(16'hFFFF, 13'd0, 14'd0, 8'd255);
    run_phase(60, 0, PHASE_TOWERS);

    drain();
    write_settings(16'd0, 13'd8191, 14'd12868, 8'd2);
    run_phase(0, 60, PHASE_TOWERS);

    drain();
    write_settings(16'd500, 13'd4000, 14'd3000, 8'd5);
    run_phase(32, 32, PHASE_TOWERS);

    drain();
    $display("sent %0d words: directed edge cases, then four idle/stall mixes", towers);
    $display("checked %0d seed words, %0d of them from full sectors", word_count, full_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
